// ===== sv/glos_pkg.sv =====
// Shared types, constants and helpers for the grid line-of-sight checker.
// Used by every module of the block but the RAM; no dependencies.
package glos_pkg;

	// grid store geometry and point format
	localparam int MAX_ROWS  = 256;
	localparam int MAX_COLS  = 256;
	localparam int FRAC_BITS = 16;
	localparam int PT_W      = 28;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int CRD_W     = PT_W - FRAC_BITS;
	localparam int DIM_W     = 9;

	// crossing parameters, unsigned Q2.30
	localparam int T_W       = 32;
	localparam int T_FRAC    = 30;
	localparam int DIST_W    = FRAC_BITS + 1;
	localparam int MAG_W     = PT_W + 1;
	localparam logic [T_W-1:0] T_INF   = '1;
	localparam logic [T_W-1:0] TIE_EPS = T_W'(1) << (T_FRAC - 16);

	// walk length guard
	localparam int GUARD_MAX = MAX_ROWS + MAX_COLS + 2;
	localparam int GUARD_W   = $clog2(GUARD_MAX + 1);

	// item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic                   command;
		logic [7:0]             cell_row;
		logic [7:0]             cell_col;
		logic                   blocked;
		logic signed [PT_W-1:0] start_x;
		logic signed [PT_W-1:0] start_z;
		logic signed [PT_W-1:0] end_x;
		logic signed [PT_W-1:0] end_z;
	} item_t;

	// saturating add of crossing parameters
	function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
		logic [T_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[T_W] ? T_INF : s[T_W-1:0];
	endfunction

endpackage

// ===== sv/glos_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glos_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/glos_front.sv =====
// Front end: accepts items and holds them in a two-entry queue for the walker.
// Depends on glos_pkg.
module glos_front import glos_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  head_valid,
	output item_t head_item,
	input  logic  deq
);

	item_t      slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_item  = slot_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = deq && head_valid;

	// payload slots
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wp_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wp_q <= !wp_q;
			if (do_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== sv/glos_div.sv =====
// Bit-serial divider for crossing parameters: (numer << 30) / mag, saturated.
// Depends on glos_pkg.
module glos_div import glos_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] numer,
	input  logic [MAG_W-1:0]  mag,
	output logic              done,
	output logic [T_W-1:0]    quot
);

	localparam int HI = T_W - T_FRAC;

	logic                     busy_q, done_q;
	logic [MAG_W-1:0]         rem_q, mag_q;
	logic [T_W-1:0]           lo_q;
	logic [$clog2(T_W+1)-1:0] cnt_q;
	logic [MAG_W:0]           rem2;
	logic                     ge;
	logic                     sat;

	// quotient overflows 32 bits when numer >= mag * 4
	assign sat  = (mag == '0) || ({{(MAG_W+HI-DIST_W){1'b0}}, numer} >= {mag, {HI{1'b0}}});
	assign rem2 = {rem_q, lo_q[T_W-1]};
	assign ge   = rem2 >= {1'b0, mag_q};
	assign done = done_q;
	assign quot = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($bits(cnt_q))'(T_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle shifted into lo_q
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			mag_q <= mag;
			if (sat) begin
				lo_q <= T_INF;
			end else begin
				rem_q <= MAG_W'(numer >> HI);
				lo_q  <= {numer[HI-1:0], {T_FRAC{1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? MAG_W'(rem2 - {1'b0, mag_q}) : rem2[MAG_W-1:0];
			lo_q  <= {lo_q[T_W-2:0], ge};
		end
	end

endmodule

// ===== sv/glos_walk.sv =====
// Back end: applies map writes and walks query segments cell by cell.
// Depends on glos_pkg, glos_ram and glos_div.
module glos_walk import glos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] rows_eff,
	input  logic [DIM_W-1:0] cols_eff,
	input  logic             head_valid,
	input  item_t            head_item,
	output logic             deq,
	output logic             clearing,
	output logic             res_valid,
	output logic             res_clear,
	input  logic             res_pop
);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_EV    = 4'd3;
	localparam logic [3:0] ST_PT2   = 4'd4;
	localparam logic [3:0] ST_SETUP = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_LOOP  = 4'd7;
	localparam logic [3:0] ST_TIE2  = 4'd8;
	localparam logic [3:0] ST_TSTEP = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]              state_q, ret_q;
	logic [ADDR_W-1:0]       clr_q;
	item_t                   qi_q;
	logic signed [CRD_W-1:0] x_q, z_q, endx_q, endz_q, chk_r_q, chk_c_q;
	logic signed [1:0]       stx_q, stz_q;
	logic [T_W-1:0]          nx_q, nz_q, dlx_q, dlz_q;
	logic [GUARD_W-1:0]      guard_q;
	logic [1:0]              op_q;
	logic                    inb_q, res_q;
	logic                    out_valid_q, out_clear_q;

	// map port
	logic              ram_we, ram_wdata, ram_re, ram_rdata;
	logic [ADDR_W-1:0] ram_waddr;

	// axis setup terms
	logic signed [MAG_W-1:0] dx, dz;
	logic [MAG_W-1:0]        magx, magz, div_mag;
	logic [DIST_W-1:0]       distx, distz, div_dist;
	logic                    div_start, div_done;
	logic [T_W-1:0]          div_quot;
	logic [1:0]              op_sel;

	// walk step terms
	logic                    at_endx, at_endz, tie, inb;
	logic [T_W-1:0]          nxe, nze, diff;
	logic signed [CRD_W-1:0] x_nx, z_nx;

	glos_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr ({chk_r_q[ROW_W-1:0], chk_c_q[COL_W-1:0]}),
		.rdata (ram_rdata)
	);

	glos_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_dist),
		.mag    (div_mag),
		.done   (div_done),
		.quot   (div_quot)
	);

	// segment deltas and distance to the first boundary on each axis
	always_comb begin
		dx    = MAG_W'(qi_q.end_x) - MAG_W'(qi_q.start_x);
		dz    = MAG_W'(qi_q.end_z) - MAG_W'(qi_q.start_z);
		magx  = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		magz  = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
		distx = dx[MAG_W-1] ? {1'b0, qi_q.start_x[FRAC_BITS-1:0]}
			: (DIST_W'(1) << FRAC_BITS) - {1'b0, qi_q.start_x[FRAC_BITS-1:0]};
		distz = dz[MAG_W-1] ? {1'b0, qi_q.start_z[FRAC_BITS-1:0]}
			: (DIST_W'(1) << FRAC_BITS) - {1'b0, qi_q.start_z[FRAC_BITS-1:0]};
		// a division started on a done pulse takes the next operand pair
		op_sel = (state_q == ST_DIV) ? op_q + 2'd1 : op_q;
		case (op_sel)
			2'd0:    begin div_dist = distx; div_mag = magx; end
			2'd1:    begin div_dist = DIST_W'(1) << FRAC_BITS; div_mag = magx; end
			2'd2:    begin div_dist = distz; div_mag = magz; end
			default: begin div_dist = DIST_W'(1) << FRAC_BITS; div_mag = magz; end
		endcase
	end

	// crossing choice for one walk step
	always_comb begin
		at_endx = x_q == endx_q;
		at_endz = z_q == endz_q;
		nxe     = at_endx ? T_INF : nx_q;
		nze     = at_endz ? T_INF : nz_q;
		diff    = (nxe > nze) ? nxe - nze : nze - nxe;
		tie     = (diff < TIE_EPS) && (nxe != T_INF);
		x_nx    = x_q + CRD_W'(stx_q);
		z_nx    = z_q + CRD_W'(stz_q);
		inb     = !chk_r_q[CRD_W-1] && !chk_c_q[CRD_W-1]
			&& ({1'b0, chk_r_q[CRD_W-2:0]} < CRD_W'(rows_eff))
			&& ({1'b0, chk_c_q[CRD_W-2:0]} < CRD_W'(cols_eff));
	end

	// control strobes
	always_comb begin
		deq       = (state_q == ST_IDLE) && head_valid;
		ram_re    = state_q == ST_RD;
		ram_we    = (state_q == ST_CLR) || (deq && head_item.command == CMD_WRITE);
		ram_waddr = (state_q == ST_CLR) ? clr_q
			: {head_item.cell_row[ROW_W-1:0], head_item.cell_col[COL_W-1:0]};
		ram_wdata = (state_q != ST_CLR) && head_item.blocked;
		div_start = (state_q == ST_SETUP) || ((state_q == ST_DIV) && div_done && op_q != 2'd3);
	end

	assign clearing  = state_q == ST_CLR;
	assign res_valid = out_valid_q;
	assign res_clear = out_clear_q;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			ret_q       <= ST_IDLE;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded from the walk, emptied by a pop
			if (state_q == ST_OUT && (!out_valid_q || res_pop))
				out_valid_q <= 1'b1;
			else if (res_pop && out_valid_q)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (head_valid && head_item.command == CMD_QUERY) begin
						ret_q   <= ST_PT2;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EV;
				ST_EV: state_q <= (!inb_q || ram_rdata) ? ST_OUT : ret_q;
				ST_PT2: begin
					ret_q   <= ST_SETUP;
					state_q <= ST_RD;
				end
				ST_SETUP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done && op_q == 2'd3)
						state_q <= ST_LOOP;
				end
				ST_LOOP: begin
					if ((at_endx && at_endz) || guard_q >= GUARD_W'(GUARD_MAX)) begin
						state_q <= ST_OUT;
					end else begin
						ret_q   <= tie ? ST_TIE2 : ST_LOOP;
						state_q <= ST_RD;
					end
				end
				ST_TIE2: begin
					ret_q   <= ST_TSTEP;
					state_q <= ST_RD;
				end
				ST_TSTEP: begin
					ret_q   <= ST_LOOP;
					state_q <= ST_RD;
				end
				ST_OUT: begin
					if (!out_valid_q || res_pop)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qi_q    <= head_item;
				chk_r_q <= head_item.start_x[PT_W-1:FRAC_BITS];
				chk_c_q <= head_item.start_z[PT_W-1:FRAC_BITS];
			end
			ST_RD: inb_q <= inb;
			ST_EV: res_q <= 1'b0;
			ST_PT2: begin
				chk_r_q <= qi_q.end_x[PT_W-1:FRAC_BITS];
				chk_c_q <= qi_q.end_z[PT_W-1:FRAC_BITS];
				op_q    <= 2'd0;
			end
			ST_SETUP: begin
				x_q    <= qi_q.start_x[PT_W-1:FRAC_BITS];
				z_q    <= qi_q.start_z[PT_W-1:FRAC_BITS];
				endx_q <= qi_q.end_x[PT_W-1:FRAC_BITS];
				endz_q <= qi_q.end_z[PT_W-1:FRAC_BITS];
				stx_q  <= dx[MAG_W-1] ? -2'sd1 : ((dx != '0) ? 2'sd1 : 2'sd0);
				stz_q  <= dz[MAG_W-1] ? -2'sd1 : ((dz != '0) ? 2'sd1 : 2'sd0);
				op_q   <= 2'd0;
			end
			ST_DIV: begin
				if (div_done) begin
					case (op_q)
						2'd0:    nx_q  <= div_quot;
						2'd1:    dlx_q <= div_quot;
						2'd2:    nz_q  <= div_quot;
						default: dlz_q <= div_quot;
					endcase
					op_q    <= op_q + 1'b1;
					guard_q <= '0;
				end
			end
			ST_LOOP: begin
				res_q   <= at_endx && at_endz;
				guard_q <= guard_q + 1'b1;
				if (tie) begin
					nx_q    <= nxe;
					nz_q    <= nze;
					chk_r_q <= x_nx;
					chk_c_q <= z_q;
				end else if (nxe < nze) begin
					x_q     <= x_nx;
					nx_q    <= sat_add(nxe, dlx_q);
					nz_q    <= nze;
					chk_r_q <= x_nx;
					chk_c_q <= z_q;
				end else begin
					z_q     <= z_nx;
					nz_q    <= sat_add(nze, dlz_q);
					nx_q    <= nxe;
					chk_r_q <= x_q;
					chk_c_q <= z_nx;
				end
			end
			ST_TIE2: begin
				chk_r_q <= x_q;
				chk_c_q <= z_nx;
			end
			ST_TSTEP: begin
				x_q     <= x_nx;
				z_q     <= z_nx;
				nx_q    <= sat_add(nx_q, dlx_q);
				nz_q    <= sat_add(nz_q, dlz_q);
				chk_r_q <= x_nx;
				chk_c_q <= z_nx;
			end
			ST_OUT: begin
				if (!out_valid_q || res_pop)
					out_clear_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/grid_line_of_sight_check.sv =====
// Grid line-of-sight checker. After reset the block clears its 65536-cell blocked map,
// one cell per cycle with full held high; configuration writes are taken
// meanwhile. A cell write is written to the map as it leaves the front queue. A query
// checks the start cell and the end cell, runs four serial divisions on one shared
// divider (a division ends early when its quotient saturates), then checks each
// stepped cell, and both side cells and the diagonal cell at a corner, all bound by
// the single map read port, and then posts the answer.
// A two-entry input queue and a one-entry result register let either side stall on its own.
module grid_line_of_sight_check import glos_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   command,
	input  logic [7:0]             cell_row,
	input  logic [7:0]             cell_col,
	input  logic                   blocked,
	input  logic signed [PT_W-1:0] start_x,
	input  logic signed [PT_W-1:0] start_z,
	input  logic signed [PT_W-1:0] end_x,
	input  logic signed [PT_W-1:0] end_z,
	output logic                   empty,
	input  logic                   pop,
	output logic                   line_clear,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [DIM_W-1:0] rows_q, cols_q, rows_eff, cols_eff;
	logic             q_full, head_valid, deq, clearing, res_valid;
	item_t            in_item, head_item;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(256);
			cols_q <= DIM_W'(256);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_ROWS)
				rows_q <= pwdata[DIM_W-1:0];
			else
				cols_q <= pwdata[DIM_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_COLS) ? {{(32-DIM_W){1'b0}}, cols_q}
		: {{(32-DIM_W){1'b0}}, rows_q};

	// grid size limited to 1..MAX
	assign rows_eff = (rows_q == '0) ? DIM_W'(1)
		: (rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_q;
	assign cols_eff = (cols_q == '0) ? DIM_W'(1)
		: (cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_q;

	always_comb begin
		in_item.command  = command;
		in_item.cell_row = cell_row;
		in_item.cell_col = cell_col;
		in_item.blocked  = blocked;
		in_item.start_x  = start_x;
		in_item.start_z  = start_z;
		in_item.end_x    = end_x;
		in_item.end_z    = end_z;
	end

	assign full  = q_full || clearing;
	assign empty = !res_valid;

	glos_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && !clearing),
		.push_item  (in_item),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.deq        (deq)
	);

	glos_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rows_eff   (rows_eff),
		.cols_eff   (cols_eff),
		.head_valid (head_valid),
		.head_item  (head_item),
		.deq        (deq),
		.clearing   (clearing),
		.res_valid  (res_valid),
		.res_clear  (line_clear),
		.res_pop    (pop)
	);

endmodule

// ===== sv/glos_chk.sv =====
// Port-level checker for the grid line-of-sight checker, bound to the top level.
// Depends on glos_pkg.
module glos_chk import glos_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   push,
	input logic                   full,
	input logic                   command,
	input logic [7:0]             cell_row,
	input logic [7:0]             cell_col,
	input logic                   blocked,
	input logic signed [PT_W-1:0] start_x,
	input logic signed [PT_W-1:0] start_z,
	input logic signed [PT_W-1:0] end_x,
	input logic signed [PT_W-1:0] end_z,
	input logic                   empty,
	input logic                   pop,
	input logic                   line_clear,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic [2:0]             paddr,
	input logic [31:0]            pwdata,
	input logic [31:0]            prdata,
	input logic                   pready
);

	// a waiting result stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped before pop");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(line_clear))
		else $error("waiting result changed");

	// map clear pass holds off input right after reset
	a_clear_full: assert property (@(posedge clk)
		$rose(arst_n) |-> full && empty)
		else $error("input open during map clear");

	// a written grid row count reads back
	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_ROWS
		|=> (paddr[2] != REG_ROWS) || (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0])))
		else $error("grid rows readback mismatch");

endmodule

bind grid_line_of_sight_check glos_chk u_glos_chk (.*);

// ===== test/grid_line_of_sight_check_checker.sv =====
// Checker for the grid line-of-sight block: mirrors the blocked map and the grid size,
// predicts the answer of each accepted query request and compares it with each popped result.
// Depends on glos_pkg.
module grid_line_of_sight_check_checker import glos_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   full,
	input  logic                   command,
	input  logic [7:0]             cell_row,
	input  logic [7:0]             cell_col,
	input  logic                   blocked,
	input  logic signed [PT_W-1:0] start_x,
	input  logic signed [PT_W-1:0] start_z,
	input  logic signed [PT_W-1:0] end_x,
	input  logic signed [PT_W-1:0] end_z,
	input  logic                   empty,
	input  logic                   pop,
	input  logic                   line_clear,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	bit        wall_map [MAP_DEPTH];
	bit [8:0]  rows_reg;
	bit [8:0]  cols_reg;
	bit        clear_answers [$];

	assign pending = clear_answers.size();

	function automatic longint eff_rows();
		if (rows_reg < 1) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return rows_reg;
	endfunction

	function automatic longint eff_cols();
		if (cols_reg < 1) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return cols_reg;
	endfunction

	function automatic bit walkable(longint r, longint c);
		if (r < 0 || c < 0 || r >= eff_rows() || c >= eff_cols()) return 0;
		return !wall_map[r * MAX_COLS + c];
	endfunction

	function automatic bit point_inside(longint px, longint pz);
		if (px < 0 || pz < 0) return 0;
		if (px >= (eff_rows() <<< FRAC_BITS) || pz >= (eff_cols() <<< FRAC_BITS)) return 0;
		return walkable(px >>> FRAC_BITS, pz >>> FRAC_BITS);
	endfunction

	function automatic longint t_quot(longint span, longint mag);
		longint q;
		q = (span <<< T_FRAC) / mag;
		return (q > longint'(T_INF)) ? longint'(T_INF) : q;
	endfunction

	function automatic longint t_sum(longint a, longint b);
		return (a + b > longint'(T_INF)) ? longint'(T_INF) : a + b;
	endfunction

	// step, first crossing and spacing along one axis
	function automatic void axis_prep(longint s, longint e, longint c,
			output longint stp, output longint nxt, output longint dlt);
		longint d;
		d = e - s;
		stp = 0;
		nxt = T_INF;
		dlt = T_INF;
		if (d > 0) begin
			stp = 1;
			nxt = t_quot(((c + 1) <<< FRAC_BITS) - s, d);
			dlt = t_quot(longint'(1) <<< FRAC_BITS, d);
		end else if (d < 0) begin
			stp = -1;
			nxt = t_quot(s - (c <<< FRAC_BITS), -d);
			dlt = t_quot(longint'(1) <<< FRAC_BITS, -d);
		end
	endfunction

	// Amanatides-Woo walk between the two points
	function automatic bit sight_line(longint sx, longint sz, longint ex, longint ez);
		longint x, z, tx, tz, stx, stz, nx, nz, dx, dz, diff;
		int steps;
		if (!point_inside(sx, sz) || !point_inside(ex, ez)) return 0;
		x = sx >>> FRAC_BITS;
		z = sz >>> FRAC_BITS;
		tx = ex >>> FRAC_BITS;
		tz = ez >>> FRAC_BITS;
		axis_prep(sx, ex, x, stx, nx, dx);
		axis_prep(sz, ez, z, stz, nz, dz);
		steps = 0;
		while (x != tx || z != tz) begin
			if (steps >= GUARD_MAX) return 0;
			steps++;
			if (x == tx) nx = T_INF;
			if (z == tz) nz = T_INF;
			diff = (nx > nz) ? nx - nz : nz - nx;
			if (diff < longint'(TIE_EPS) && nx != longint'(T_INF)) begin
				// diagonal corner: both side cells must be open
				if (!walkable(x + stx, z) || !walkable(x, z + stz)) return 0;
				x += stx;
				z += stz;
				nx = t_sum(nx, dx);
				nz = t_sum(nz, dz);
			end else if (nx < nz) begin
				x += stx;
				nx = t_sum(nx, dx);
			end else begin
				z += stz;
				nz = t_sum(nz, dz);
			end
			if (!walkable(x, z)) return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			foreach (wall_map[i]) wall_map[i] = 0;
			rows_reg = 256;
			cols_reg = 256;
			clear_answers.delete();
			fail_count = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_COLS) cols_reg = pwdata[8:0];
				else rows_reg = pwdata[8:0];
			end
			// compare popped result
			if (pop && !empty) begin
				if (clear_answers.size() == 0) begin
					$error("result popped with no query pending: line_clear=%0d", line_clear);
					fail_count++;
				end else begin
					want = clear_answers.pop_front();
					if (line_clear !== want) begin
						$error("line_clear expected %0d actual %0d", want, line_clear);
						fail_count++;
					end
				end
			end
			// accepted requests
			if (push && !full) begin
				if (command == CMD_WRITE) wall_map[{cell_row, cell_col}] = blocked;
				else clear_answers = {clear_answers,
					sight_line(start_x, start_z, end_x, end_z)};
			end
		end
	end
endmodule

// ===== test/grid_line_of_sight_check_test.sv =====
// Top of the grid line-of-sight testbench: clock, reset, register writes, cell-write and
// query requests with random idling. Depends on glos_pkg, the block and its checker.
module grid_line_of_sight_check_test;
	import glos_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0, pop = 0;
	logic command = 0, blocked = 0;
	logic [7:0] cell_row = 0, cell_col = 0;
	logic signed [PT_W-1:0] start_x = 0, start_z = 0, end_x = 0, end_z = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic full, empty, line_clear, pready;
	logic [31:0] prdata;
	int fail_count, pending;
	longint cycle_count = 0;
	bit calm = 0;
	int rows_now = 256, cols_now = 256;

	always #1 clk = ~clk;

	grid_line_of_sight_check uut (.*);
	grid_line_of_sight_check_checker chk (.*);

	// run limit: map clear plus longest walks under stalls, many times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 20000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random pop stalls in bursts
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 4);
				pop <= 0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
		end
	end

	task automatic reg_write(input logic idx, input int val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_ROWS) rows_now = (val & 511) < 1 ? 1 : ((val & 511) > 256 ? 256 : val & 511);
		else cols_now = (val & 511) < 1 ? 1 : ((val & 511) > 256 ? 256 : val & 511);
	endtask

	task automatic send(input item_t it);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		command <= it.command; cell_row <= it.cell_row; cell_col <= it.cell_col;
		blocked <= it.blocked;
		start_x <= it.start_x; start_z <= it.start_z; end_x <= it.end_x; end_z <= it.end_z;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic cell_set(input int r, input int c, input bit b);
		item_t it;
		it = '0;
		it.command = CMD_WRITE;
		it.cell_row = 8'(r); it.cell_col = 8'(c); it.blocked = b;
		it.start_x = PT_W'($urandom); it.start_z = PT_W'($urandom);
		it.end_x = PT_W'($urandom); it.end_z = PT_W'($urandom);
		send(it);
	endtask

	task automatic sight(input int sx, input int sz, input int ex, input int ez);
		item_t it;
		it = '0;
		it.command = CMD_QUERY;
		it.cell_row = 8'($urandom); it.cell_col = 8'($urandom); it.blocked = 1'($urandom);
		it.start_x = PT_W'(sx); it.start_z = PT_W'(sz); it.end_x = PT_W'(ex); it.end_z = PT_W'(ez);
		send(it);
	endtask

	// point mostly inside the current grid, sometimes near or past its edge
	function automatic int coord(input int n);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return -$urandom_range(1, 70000);
			2: return (n << FRAC_BITS) + $urandom_range(0, 3) - 1;
			3: return ($urandom_range(0, n - 1) << FRAC_BITS);
			default: return $urandom_range(0, (n << FRAC_BITS) - 1);
		endcase
	endfunction

	// stop input, drain all results, then idle for the block to settle
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int sizes [6] = '{256, 1, 2, 5, 16, 256};
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		reg_write(REG_ROWS, 256);
		reg_write(REG_COLS, 256);

		// directed: extremes, corner ties, blocked ends and out-of-range points
		sight(0, 0, (256 << 16) - 1, (256 << 16) - 1);
		sight(32'h07FF_FFFF, 0, 0, 0);
		sight(32'hF800_0000, 0, 0, 0);
		sight(0, 0, 0, 0);
		sight(5 << 16, 5 << 16, 5 << 16, 9 << 16);
		cell_set(3, 3, 1);
		cell_set(255, 255, 1);
		sight(3 << 16 | 16'h8000, 3 << 16, 10 << 16, 10 << 16);
		sight(10 << 16, 10 << 16, 3 << 16, 3 << 16);
		sight(1 << 16 | 16'h8000, 2 << 16 | 16'h8000, 2 << 16 | 16'h8000, 1 << 16 | 16'h8000);
		cell_set(2, 4, 1);
		sight(2 << 16 | 16'h8000, 3 << 16 | 16'h8000, 3 << 16 | 16'h8000, 4 << 16 | 16'h8000);
		sight(100 << 16, 0, 100 << 16 | 16'hFFFF, (256 << 16) - 1);
		sight(255 << 16, 0, 0, 255 << 16);
		cell_set(3, 3, 0);
		cell_set(2, 4, 0);
		cell_set(255, 255, 0);
		sight(3 << 16 | 16'h8000, 3 << 16, 10 << 16, 10 << 16);
		drain();
		reg_write(REG_ROWS, 0);
		reg_write(REG_COLS, 511);
		sight(0, 0, 0, 200 << 16);
		sight(1 << 16, 0, 0, 0);
		drain();

		// random phases over several grid sizes
		for (int ph = 0; ph < 6; ph++) begin
			n = sizes[ph];
			reg_write(REG_ROWS, ph == 5 ? 300 : n);
			reg_write(REG_COLS, (ph % 2) ? n : (n > 4 ? n / 2 + 1 : n));
			if (ph == 5) calm = 1;
			for (int i = 0; i < 275; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 7) == 0) cell_set($urandom, $urandom, 1'($urandom));
					else cell_set($urandom_range(0, rows_now - 1), $urandom_range(0, cols_now - 1),
						$urandom_range(0, 2) == 0);
				end else if ($urandom_range(0, 9) == 0) begin
					sight($urandom, $urandom, $urandom, $urandom);
				end else begin
					sight(coord(rows_now), coord(cols_now), coord(rows_now), coord(cols_now));
				end
			end
			drain();
		end

		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
